/* rtl/smn_pkg.sv */
// constants for the scaled median block and the sizing of its value store
package smn_pkg;

   localparam int MAX_CELLS  = 4096;
   localparam int COUNT_BITS = 24;

   localparam int ADDR_W  = $clog2(MAX_CELLS);
   localparam int TOTAL_W = $clog2(MAX_CELLS + 1);
   localparam int MOD_W   = 16;
   localparam int FRAC_W  = 8;
   localparam int THR_W   = 32;
   localparam int NZ_W    = 13;
   localparam int PROD_W  = COUNT_BITS + MOD_W;

   localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(256);

   localparam int TDATA_W = ((THR_W + NZ_W + 7) / 8) * 8;

endpackage

/* rtl/scaled_median_of_nonzero.sv */
// scaled median of the nonzero cell counts of a frame
//
//  channel  direction  beat contents (low bits first)
//  req      in         tdata: cell_count[23:0]; tlast: frame_end
//  rsp      out        tdata: threshold[31:0], nonzero_cells[44:32], zero pad;
//                      tuser: frame_empty[0], overflowed[1]
//  csr      in         wdata: modifier_q8[15:0], written when csr_wen is high
//
// loading takes one beat per cycle, only in the load state; nonzero counts go
// into a 4096-entry ram; at frame end a radix selection makes one ram pass per
// count bit (24 passes), each pass reading all stored values and then deciding
// the bit, both middle ranks found together; then averaging, multiply, output
// reset clears the control state and sets the modifier to 1.0; no ram clear
// a finished result waits in the output register while the next frame loads
module scaled_median_of_nonzero
   import smn_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [COUNT_BITS-1:0]   req_tdata,   // cell_count
   input  logic                    req_tlast,   // frame_end
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [TDATA_W-1:0]      rsp_tdata,   // threshold, nonzero_cells, pad
   output logic [1:0]              rsp_tuser,   // frame_empty, overflowed
   input  logic                    csr_wen,
   input  logic [MOD_W-1:0]        csr_wdata    // modifier_q8
);

   // sequencer states
   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_AVG    = 3'd3;
   localparam logic [2:0] ST_MUL    = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [MOD_W-1:0]      modifier_ff, modifier_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic                  ovf_ff, ovf_in;

   // selection state: two ranks tracked in the same pass
   logic [COUNT_BITS-1:0] bit_ff, bit_in;       // one-hot bit under test
   logic [COUNT_BITS-1:0] high_ff, high_in;     // bits already decided
   logic [COUNT_BITS-1:0] pfx_a_ff, pfx_a_in;
   logic [COUNT_BITS-1:0] pfx_b_ff, pfx_b_in;
   logic [TOTAL_W-1:0]    k_a_ff, k_a_in;
   logic [TOTAL_W-1:0]    k_b_ff, k_b_in;
   logic [TOTAL_W-1:0]    zero_a_ff, zero_a_in;
   logic [TOTAL_W-1:0]    zero_b_ff, zero_b_in;
   logic [TOTAL_W-1:0]    issue_ff, issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rd_last_ff, rd_last_in;

   logic [COUNT_BITS-1:0] med_ff, med_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   // output register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [THR_W-1:0]      thr_ff, thr_in;
   logic [NZ_W-1:0]       nz_ff, nz_in;
   logic                  empty_ff, empty_in;
   logic                  ovf_out_ff, ovf_out_in;

   logic                  req_acc;
   logic                  store_wr;
   logic                  issuing;
   logic [COUNT_BITS-1:0] rd_data;
   logic                  hit_a, hit_b;
   logic [COUNT_BITS:0]   pair_sum;
   logic [63:0]           scaled;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign store_wr   = req_acc && (req_tdata != '0) && (total_ff < TOTAL_W'(MAX_CELLS));
   assign issuing    = (state_ff == ST_SCAN) && (issue_ff < total_ff);

   smn_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MAX_CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (total_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (issuing),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // a value counts as a zero at this bit when it matches the decided prefix
   assign hit_a = ((rd_data & high_ff) == pfx_a_ff) && ((rd_data & bit_ff) == '0);
   assign hit_b = ((rd_data & high_ff) == pfx_b_ff) && ((rd_data & bit_ff) == '0);

   assign pair_sum = {1'b0, pfx_a_ff} + {1'b0, pfx_b_ff};
   assign scaled   = 64'(prod_ff >> FRAC_W);

   always_comb begin
      state_in    = state_ff;
      modifier_in = csr_wen ? csr_wdata : modifier_ff;
      total_in    = total_ff;
      ovf_in      = ovf_ff;
      bit_in      = bit_ff;
      high_in     = high_ff;
      pfx_a_in    = pfx_a_ff;
      pfx_b_in    = pfx_b_ff;
      k_a_in      = k_a_ff;
      k_b_in      = k_b_ff;
      zero_a_in   = zero_a_ff;
      zero_b_in   = zero_b_ff;
      issue_in    = issue_ff;
      rd_vld_in   = issuing;
      rd_last_in  = issuing && (issue_ff == total_ff - TOTAL_W'(1));
      med_in      = med_ff;
      prod_in     = prod_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      thr_in      = thr_ff;
      nz_in       = nz_ff;
      empty_in    = empty_ff;
      ovf_out_in  = ovf_out_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (store_wr) begin
                  total_in = total_ff + TOTAL_W'(1);
               end else if (req_tdata != '0) begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  bit_in    = {1'b1, {(COUNT_BITS-1){1'b0}}};
                  high_in   = '0;
                  pfx_a_in  = '0;
                  pfx_b_in  = '0;
                  k_a_in    = (total_in - TOTAL_W'(1)) >> 1;
                  k_b_in    = total_in >> 1;
                  zero_a_in = '0;
                  zero_b_in = '0;
                  issue_in  = '0;
                  // empty frame skips selection, prefixes stay zero
                  state_in  = (total_in == '0) ? ST_AVG : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               issue_in = issue_ff + TOTAL_W'(1);
            end
            if (rd_vld_ff) begin
               zero_a_in = zero_a_ff + TOTAL_W'(hit_a);
               zero_b_in = zero_b_ff + TOTAL_W'(hit_b);
               if (rd_last_ff) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (k_a_ff >= zero_a_ff) begin
               k_a_in   = k_a_ff - zero_a_ff;
               pfx_a_in = pfx_a_ff | bit_ff;
            end
            if (k_b_ff >= zero_b_ff) begin
               k_b_in   = k_b_ff - zero_b_ff;
               pfx_b_in = pfx_b_ff | bit_ff;
            end
            high_in   = high_ff | bit_ff;
            bit_in    = bit_ff >> 1;
            zero_a_in = '0;
            zero_b_in = '0;
            issue_in  = '0;
            state_in  = bit_ff[0] ? ST_AVG : ST_SCAN;
         end
         ST_AVG: begin
            med_in   = pair_sum[COUNT_BITS:1];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(med_ff) * PROD_W'(modifier_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for a previous result still held in the output register
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               thr_in     = (scaled[63:THR_W] != '0) ? '1 : scaled[THR_W-1:0];
               nz_in      = NZ_W'(total_ff);
               empty_in   = (total_ff == '0);
               ovf_out_in = ovf_ff;
               total_in   = '0;
               ovf_in     = 1'b0;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         modifier_ff <= MOD_RESET;
         total_ff    <= '0;
         ovf_ff      <= 1'b0;
         rd_vld_ff   <= 1'b0;
         rd_last_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         modifier_ff <= modifier_in;
         total_ff    <= total_in;
         ovf_ff      <= ovf_in;
         rd_vld_ff   <= rd_vld_in;
         rd_last_ff  <= rd_last_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff     <= bit_in;
      high_ff    <= high_in;
      pfx_a_ff   <= pfx_a_in;
      pfx_b_ff   <= pfx_b_in;
      k_a_ff     <= k_a_in;
      k_b_ff     <= k_b_in;
      zero_a_ff  <= zero_a_in;
      zero_b_ff  <= zero_b_in;
      issue_ff   <= issue_in;
      med_ff     <= med_in;
      prod_ff    <= prod_in;
      thr_ff     <= thr_in;
      nz_ff      <= nz_in;
      empty_ff   <= empty_in;
      ovf_out_ff <= ovf_out_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = TDATA_W'({nz_ff, thr_ff});
   assign rsp_tuser  = {ovf_out_ff, empty_ff};

endmodule

/* rtl/smn_ram.sv */
// generic simple dual-port ram with registered read
module smn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
